// ===== rtl/core/huffman_byte_decoder_unit_macros.svh =====
// assertion macros shared by the huffman byte decoder rtl
`ifndef HUFFMAN_BYTE_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_BYTE_DECODER_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define HBD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define HBD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hbd_pkg.sv =====
// types and constants of the huffman byte decoder
`default_nettype none

package hbd_pkg;

   localparam int NODE_W     = 9;
   localparam int INDEX_W    = 8;
   localparam int SYMBOL_W   = 8;
   localparam int COUNT_W    = 16;
   localparam int LENGTH_BITS = 16;
   localparam int ENTRY_W    = 2 * NODE_W;

   localparam logic [NODE_W-1:0] FIRST_INTERNAL = 9'd256;
   localparam logic [4:0] LENGTH_START = 5'(LENGTH_BITS - 1);
   localparam logic [4:0] LEAF_BITS = 5'd8;

   typedef enum logic [2:0] {
      PH_ROOT    = 3'd0,
      PH_LEFT    = 3'd1,
      PH_RIGHT   = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_SYMBOLS = 3'd4,
      PH_DONE    = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   // half-entry write into the child table
   typedef struct packed {
      logic               wr_left;
      logic               wr_right;
      logic [INDEX_W-1:0] index;
      logic [NODE_W-1:0]  node;
   } child_wr_type;

   // pending-node stack access
   typedef struct packed {
      logic               wr_en;
      logic [INDEX_W-1:0] wr_index;
      logic [NODE_W-1:0]  wr_node;
      logic [INDEX_W-1:0] rd_index;
   } stack_port_type;

endpackage

`default_nettype wire

// ===== rtl/core/hbd_child_mem.sv =====
// child table: left and right child of each internal node, half writes, registered read
`default_nettype none

module hbd_child_mem (
   input  wire                      clock,
   input  wire  hbd_pkg::child_wr_type child_wr,
   input  wire  [7:0]               rd_index,
   output logic [17:0]              rd_entry
);
   import hbd_pkg::*;

   logic [ENTRY_W-1:0] table_mem [0:(1 << INDEX_W)-1];

   always_ff @(posedge clock) begin
      if (child_wr.wr_left) begin
         table_mem[child_wr.index][ENTRY_W-1:NODE_W] <= child_wr.node;
      end
      if (child_wr.wr_right) begin
         table_mem[child_wr.index][NODE_W-1:0] <= child_wr.node;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry <= table_mem[rd_index];
   end

endmodule

`default_nettype wire

// ===== rtl/core/hbd_stack_mem.sv =====
// pending-node stack memory with top-of-stack read and write forwarding
`default_nettype none

module hbd_stack_mem (
   input  wire                      clock,
   input  wire  hbd_pkg::stack_port_type stack_port,
   output logic [8:0]               rd_node
);
   import hbd_pkg::*;

   logic [NODE_W-1:0] stack_mem [0:(1 << INDEX_W)-1];
   logic [NODE_W-1:0] mem_q_ff;
   logic [NODE_W-1:0] fwd_node_ff;
   logic              fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (stack_port.wr_en) begin
         stack_mem[stack_port.wr_index] <= stack_port.wr_node;
      end
      mem_q_ff    <= stack_mem[stack_port.rd_index];
      fwd_node_ff <= stack_port.wr_node;
      // a push lands on the entry being read as the new top
      fwd_hit_ff  <= stack_port.wr_en && (stack_port.wr_index == stack_port.rd_index);
   end

   assign rd_node = fwd_hit_ff ? fwd_node_ff : mem_q_ff;

endmodule

`default_nettype wire

// ===== rtl/core/huffman_byte_decoder_unit.sv =====
// huffman byte decoder top level: bit engine, phase control and result register
`default_nettype none

// Takes one compressed byte per transfer and works through its eight bits
// most significant first, one bit per clock while no symbol is held back;
// the transfer is taken first, then the bit steps. Bytes arriving once the
// message is done or has failed are dropped at once. A bit that produces a
// symbol waits while the previous result is still held in the output
// register. The child table and the pending-node stack sit in two
// single-port-read memories, read every cycle at the address the next bit
// will need (the node being walked, the stack top), so tree descent and
// stack pops need no extra step. No clearing pass is needed after reset;
// req_tuser high on a byte restarts the tree phase before that byte.
module huffman_byte_decoder_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tuser,   // [0] message_start
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] symbol
   output logic        rsp_tlast,   // last_symbol
   output logic        rsp_tuser    // [0] malformed
);
   import hbd_pkg::*;

`include "huffman_byte_decoder_unit_macros.svh"

   logic [7:0]          shift_ff, shift_in;
   logic [3:0]          bits_left_ff, bits_left_in;
   phase_type           phase_ff, phase_in;
   logic [4:0]          bit_count_ff, bit_count_in;
   logic [7:0]          gather_ff, gather_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic [NODE_W-1:0]   walk_ff, walk_in;
   logic [NODE_W-1:0]   root_ff, root_in;
   logic [NODE_W-1:0]   next_free_ff, next_free_in;
   logic [NODE_W-1:0]   depth_ff, depth_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_symbol_ff, rsp_symbol_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic                busy, cur_bit, take_in, step_go;
   logic                emit, emit_last, emit_bad;
   logic [7:0]          emit_symbol;
   logic                attach_en, push_want;
   logic [NODE_W-1:0]   attach_node, leaf_node, child_node, stack_top, depth_dec;
   logic [NODE_W-1:0]   alloc_count;
   logic [ENTRY_W-1:0]  child_entry;
   logic [COUNT_W-1:0]  remaining_dec, remaining_shift;
   child_wr_type        child_wr;
   stack_port_type      stack_port;

   assign busy            = bits_left_ff != 4'd0;
   assign cur_bit         = shift_ff[7];
   assign req_tready      = !busy;
   assign take_in         = req_tvalid && !busy;
   assign leaf_node       = {1'b0, gather_ff[6:0], cur_bit};
   assign child_node      = cur_bit ? child_entry[NODE_W-1:0] : child_entry[ENTRY_W-1:NODE_W];
   assign remaining_dec   = remaining_ff - 16'd1;
   assign remaining_shift = {remaining_ff[COUNT_W-2:0], cur_bit};
   assign depth_dec       = depth_in - 9'd1;
   assign alloc_count     = {1'b0, next_free_ff[7:0]};
   // a symbol cannot step while the output register is still occupied
   assign step_go         = busy && !(emit && rsp_valid_ff && !rsp_tready);

   hbd_child_mem u_child_mem (
      .clock    (clock),
      .child_wr (child_wr),
      .rd_index (walk_in[7:0]),
      .rd_entry (child_entry)
   );

   hbd_stack_mem u_stack_mem (
      .clock      (clock),
      .stack_port (stack_port),
      .rd_node    (stack_top)
   );

   // per-bit outputs: results and memory writes
   always_comb begin
      emit        = 1'b0;
      emit_symbol = 8'd0;
      emit_last   = 1'b0;
      emit_bad    = 1'b0;
      attach_en   = 1'b0;
      attach_node = leaf_node;
      push_want   = 1'b0;
      if (busy) begin
         case (phase_ff)
            PH_ROOT, PH_LEFT, PH_RIGHT: begin
               if (bit_count_ff != 5'd0) begin
                  attach_en = bit_count_ff == 5'd1;
               end else if (!cur_bit) begin
                  if (!next_free_ff[8]) begin
                     emit      = 1'b1;
                     emit_last = 1'b1;
                     emit_bad  = 1'b1;
                  end else begin
                     attach_en   = 1'b1;
                     attach_node = next_free_ff;
                     push_want   = 1'b1;
                  end
               end
            end
            PH_SYMBOLS: begin
               if (!root_ff[8]) begin
                  // single-leaf tree: any bit yields the root value
                  emit        = 1'b1;
                  emit_symbol = root_ff[7:0];
                  emit_last   = remaining_dec == 16'd0;
               end else if (!child_node[8]) begin
                  emit        = 1'b1;
                  emit_symbol = child_node[7:0];
                  emit_last   = remaining_dec == 16'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      child_wr.wr_left    = step_go && attach_en && (phase_ff == PH_LEFT);
      child_wr.wr_right   = step_go && attach_en && (phase_ff == PH_RIGHT);
      child_wr.index      = walk_ff[7:0];
      child_wr.node       = attach_node;
      stack_port.wr_en    = step_go && push_want;
      stack_port.wr_index = depth_ff[7:0];
      stack_port.wr_node  = next_free_ff;
      stack_port.rd_index = depth_dec[7:0];
   end

   // next state
   always_comb begin
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      gather_in     = gather_ff;
      remaining_in  = remaining_ff;
      walk_in       = walk_ff;
      root_in       = root_ff;
      next_free_in  = next_free_ff;
      depth_in      = depth_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;

      if (take_in) begin
         if (req_tuser) begin
            depth_in     = '0;
            next_free_in = FIRST_INTERNAL;
            root_in      = '0;
            phase_in     = PH_ROOT;
            bit_count_in = '0;
            gather_in    = '0;
            remaining_in = '0;
            walk_in      = '0;
         end
         shift_in     = req_tdata;
         bits_left_in = 4'd8;
      end else if (step_go) begin
         shift_in     = {shift_ff[6:0], 1'b0};
         bits_left_in = bits_left_ff - 4'd1;
         if (emit) begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = emit_symbol;
            rsp_last_in   = emit_last;
            rsp_bad_in    = emit_bad;
         end
         case (phase_ff)
            PH_ROOT, PH_LEFT, PH_RIGHT: begin
               if (bit_count_ff != 5'd0) begin
                  gather_in    = {gather_ff[6:0], cur_bit};
                  bit_count_in = bit_count_ff - 5'd1;
                  if (bit_count_ff == 5'd1) begin
                     if (phase_ff == PH_ROOT) begin
                        root_in = leaf_node;
                     end
                     if (depth_ff == 9'd0) begin
                        phase_in     = PH_LENGTH;
                        bit_count_in = LENGTH_START;
                        remaining_in = '0;
                     end else begin
                        depth_in = depth_ff - 9'd1;
                        walk_in  = stack_top;
                        phase_in = PH_RIGHT;
                     end
                  end
               end else if (cur_bit) begin
                  bit_count_in = LEAF_BITS;
                  gather_in    = '0;
               end else if (!next_free_ff[8]) begin
                  phase_in     = PH_ERROR;
               end else begin
                  next_free_in = next_free_ff + 9'd1;
                  if (phase_ff == PH_ROOT) begin
                     root_in = next_free_ff;
                  end
                  depth_in = depth_ff + 9'd1;
                  walk_in  = next_free_ff;
                  phase_in = PH_LEFT;
               end
            end
            PH_LENGTH: begin
               remaining_in = remaining_shift;
               if (bit_count_ff == 5'd0) begin
                  walk_in  = root_ff;
                  phase_in = (remaining_shift != 16'd0) ? PH_SYMBOLS : PH_DONE;
               end else begin
                  bit_count_in = bit_count_ff - 5'd1;
               end
            end
            PH_SYMBOLS: begin
               if (root_ff[8] && child_node[8]) begin
                  walk_in = child_node;
               end else begin
                  walk_in      = root_ff;
                  remaining_in = remaining_dec;
                  if (remaining_dec == 16'd0) begin
                     phase_in = PH_DONE;
                  end
               end
            end
            default: begin
               // done or failed: the rest of the byte is dropped at once
               bits_left_in = 4'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
         phase_ff     <= PH_ROOT;
         bit_count_ff <= '0;
         gather_ff    <= '0;
         remaining_ff <= '0;
         walk_ff      <= '0;
         root_ff      <= '0;
         next_free_ff <= FIRST_INTERNAL;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bits_left_ff <= bits_left_in;
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         gather_ff    <= gather_in;
         remaining_ff <= remaining_in;
         walk_ff      <= walk_in;
         root_ff      <= root_in;
         next_free_ff <= next_free_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // stack never holds more nodes than have been allocated
   `HBD_ASSERT_IMPLY(a_stack_bound, (phase_ff == PH_ROOT || phase_ff == PH_LEFT || phase_ff == PH_RIGHT) && next_free_ff[8], depth_ff <= alloc_count, "stack deeper than allocated nodes")

   // a tree walk always sits on an internal node
   `HBD_ASSERT_IMPLY(a_walk_internal, phase_ff == PH_SYMBOLS && root_ff[8], walk_ff[8], "walk left the internal nodes")

   // an overflow result closes the message with a zero symbol
   `HBD_ASSERT_IMPLY(a_bad_result, rsp_valid_ff && rsp_bad_ff, rsp_last_ff && rsp_symbol_ff == 8'd0, "overflow result not last or not zero")

   // a finished or failed message drops the rest of a byte at once
   `HBD_ASSERT_NEXT(a_drop_rest, busy && (phase_ff == PH_DONE || phase_ff == PH_ERROR), bits_left_ff == 4'd0, "trailing bits not dropped")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the huffman byte decoder unit
`default_nettype none

module testbench;
   import hbd_pkg::*;

   localparam int CODE_W      = 260;
   localparam int MAX_LEAVES  = 257;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 40;
   localparam int RANDOM_BYTES = 500;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   huffman_byte_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // tracks the decoder state and holds the symbols still due from it
   class symbol_tracker;
      typedef struct {
         bit [SYMBOL_W-1:0] value;
         bit                last;
         bit                malformed;
      } symbol_rec_type;

      bit [ENTRY_W-1:0]  children [256];
      bit [NODE_W-1:0]   pending [256];
      bit [NODE_W-1:0]   depth;
      bit [NODE_W-1:0]   free_node;
      bit [NODE_W-1:0]   root;
      bit [NODE_W-1:0]   cursor;
      phase_type         ph;
      bit [4:0]          bits_left;
      bit [15:0]         gather;
      bit [COUNT_W-1:0]  remaining;
      symbol_rec_type    due_symbols [$];
      int                errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         depth     = '0;
         free_node = FIRST_INTERNAL;
         root      = '0;
         ph        = PH_ROOT;
         bits_left = '0;
         gather    = '0;
         remaining = '0;
         cursor    = '0;
      endfunction

      function int pending_count();
         return due_symbols.size();
      endfunction

      function void push_symbol(bit [SYMBOL_W-1:0] value, bit last, bit malformed);
         symbol_rec_type rec;
         rec.value     = value;
         rec.last      = last;
         rec.malformed = malformed;
         due_symbols.push_back(rec);
      endfunction

      // hang a node or leaf on the slot the tree phase points at
      function void attach(bit [NODE_W-1:0] x);
         if (ph == PH_ROOT) begin
            root = x;
         end else if (ph == PH_LEFT) begin
            children[cursor[INDEX_W-1:0]][ENTRY_W-1:NODE_W] = x;
         end else begin
            children[cursor[INDEX_W-1:0]][NODE_W-1:0] = x;
         end
      endfunction

      function void leaf_done(bit [NODE_W-1:0] x);
         attach(x);
         if (depth == 0) begin
            ph        = PH_LENGTH;
            bits_left = LENGTH_START;
            remaining = '0;
         end else begin
            depth  = depth - 1'b1;
            cursor = pending[depth[INDEX_W-1:0]];
            ph     = PH_RIGHT;
         end
      endfunction

      function void take_byte(bit [7:0] data, bit start);
         bit               b;
         bit               emit;
         bit [SYMBOL_W-1:0] hit;
         bit [NODE_W-1:0]  child;
         if (start)
            restart();
         for (int i = 7; i >= 0; i--) begin
            b = data[i];
            emit = 1'b0;
            if (ph == PH_ROOT || ph == PH_LEFT || ph == PH_RIGHT) begin
               if (bits_left != 0) begin
                  gather = {gather[14:0], b};
                  bits_left = bits_left - 1'b1;
                  if (bits_left == 0)
                     leaf_done({1'b0, gather[7:0]});
               end else if (b) begin
                  bits_left = LEAF_BITS;
                  gather    = '0;
               end else if (free_node < FIRST_INTERNAL) begin
                  // node store exhausted
                  push_symbol('0, 1'b1, 1'b1);
                  ph = PH_ERROR;
               end else begin
                  child     = free_node;
                  free_node = free_node + 1'b1;
                  attach(child);
                  pending[depth[INDEX_W-1:0]] = child;
                  depth  = depth + 1'b1;
                  cursor = child;
                  ph     = PH_LEFT;
               end
            end else if (ph == PH_LENGTH) begin
               remaining = {remaining[COUNT_W-2:0], b};
               if (bits_left == 0) begin
                  cursor = root;
                  if (remaining != 0)
                     ph = PH_SYMBOLS;
                  else
                     ph = PH_DONE;
               end else begin
                  bits_left = bits_left - 1'b1;
               end
            end else if (ph == PH_SYMBOLS) begin
               if (root < FIRST_INTERNAL) begin
                  // single-leaf tree: any bit yields the root value
                  hit  = root[SYMBOL_W-1:0];
                  emit = 1'b1;
               end else begin
                  child = b ? children[cursor[INDEX_W-1:0]][NODE_W-1:0]
                            : children[cursor[INDEX_W-1:0]][ENTRY_W-1:NODE_W];
                  if (child >= FIRST_INTERNAL) begin
                     cursor = child;
                  end else begin
                     hit    = child[SYMBOL_W-1:0];
                     cursor = root;
                     emit   = 1'b1;
                  end
               end
               if (emit) begin
                  remaining = remaining - 1'b1;
                  push_symbol(hit, remaining == 0, 1'b0);
                  if (remaining == 0)
                     ph = PH_DONE;
               end
            end
         end
      endfunction

      function void check_symbol(bit [SYMBOL_W-1:0] value, bit last, bit malformed);
         symbol_rec_type want;
         if (due_symbols.size() == 0) begin
            $error("unexpected result: symbol %02h last %0b malformed %0b",
                   value, last, malformed);
            errors++;
            return;
         end
         want = due_symbols.pop_front();
         if (value != want.value) begin
            $error("symbol: expected %02h, got %02h", want.value, value);
            errors++;
         end
         if (last != want.last) begin
            $error("last_symbol: expected %0b, got %0b", want.last, last);
            errors++;
         end
         if (malformed != want.malformed) begin
            $error("malformed: expected %0b, got %0b", want.malformed, malformed);
            errors++;
         end
      endfunction
   endclass

   symbol_tracker tracker;

   bit              stream_bits [$];
   bit [CODE_W-1:0] leaf_code [MAX_LEAVES];
   int              leaf_len [MAX_LEAVES];
   int              burst_left;
   int              useful_bytes;
   int              quiet_cycles;
   int              stall_left;
   int              ready_style;
   int              cycle_no;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transfer monitor, scoreboard feed and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.take_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            tracker.check_symbol(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver: always ready, coin-flip, or ready with long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_no++;
         if (cycle_no % 97 == 0)
            ready_style = $urandom_range(0, 2);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (ready_style == 0) begin
            rsp_tready <= 1'b1;
         end else if (ready_style == 1) begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(4, 24);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input bit [7:0] data, input bit start);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the sender until every due symbol has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.pending_count() > 0) @(posedge clock);
   endtask

   // preorder tree, 16-bit count and the codes of the shown symbols
   task automatic compose_message(input int leaves, input bit spine, input int leaf_value,
                                  input bit [15:0] count, input int shown);
      int              slots;
      int              internals;
      int              n_leaf;
      int              pick;
      int              cur_len;
      bit [CODE_W-1:0] cur;
      bit [CODE_W-1:0] right_path;
      bit [CODE_W-1:0] right_code [$];
      int              right_len [$];
      bit [7:0]        value;
      bit              go_deeper;
      slots     = 1;
      internals = leaves - 1;
      n_leaf    = 0;
      cur       = '0;
      cur_len   = 0;
      while (slots > 0) begin
         if (internals == 0)
            go_deeper = 1'b0;
         else if (slots == 1 || spine)
            go_deeper = 1'b1;
         else
            go_deeper = 1'($urandom_range(0, 1));
         if (go_deeper) begin
            stream_bits.push_back(1'b0);
            right_path = cur;
            right_path[cur_len] = 1'b1;
            right_code.push_back(right_path);
            right_len.push_back(cur_len + 1);
            cur[cur_len] = 1'b0;
            cur_len++;
            internals--;
            slots++;
         end else begin
            value = (leaf_value < 0) ? 8'($urandom_range(0, 255)) : 8'(leaf_value);
            stream_bits.push_back(1'b1);
            for (int k = 7; k >= 0; k--)
               stream_bits.push_back(value[k]);
            leaf_code[n_leaf] = cur;
            leaf_len[n_leaf]  = cur_len;
            n_leaf++;
            slots--;
            if (slots > 0) begin
               cur     = right_code.pop_back();
               cur_len = right_len.pop_back();
            end
         end
      end
      for (int k = 15; k >= 0; k--)
         stream_bits.push_back(count[k]);
      for (int s = 0; s < shown; s++) begin
         pick = $urandom_range(0, n_leaf - 1);
         if (leaf_len[pick] == 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
         else
            for (int k = 0; k < leaf_len[pick]; k++)
               stream_bits.push_back(leaf_code[pick][k]);
      end
      while (stream_bits.size() % 8 != 0)
         stream_bits.push_back(1'($urandom_range(0, 1)));
   endtask

   task automatic send_stream(input bit start, input int trailing);
      bit [7:0] data;
      while (stream_bits.size() > 0) begin
         for (int k = 7; k >= 0; k--)
            data[k] = stream_bits.pop_front();
         send_byte(data, start);
         start = 1'b0;
         useful_bytes++;
      end
      repeat (trailing) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      int          msg_no;
      int          pick;
      int          leaves;
      int          shown;
      bit [15:0]   count;
      tracker      = new();
      burst_left   = 0;
      useful_bytes = 0;
      quiet_cycles = 0;
      stall_left   = 0;
      ready_style  = 0;
      cycle_no     = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single-leaf tree straight after reset, no restart flag
      compose_message(1, 1'b0, 255, 16'd3, 3);
      send_stream(1'b0, 0);
      // zero count, then a byte past the end of the message
      compose_message(1, 1'b0, 0, 16'd0, 0);
      send_stream(1'b1, 1);
      // message cut off in its count field, from an all-ones and an all-zeros byte
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      compose_message(2, 1'b0, -1, 16'd5, 5);
      send_stream(1'b1, 0);
      compose_message(3, 1'b0, -1, 16'd4, 4);
      send_stream(1'b1, 0);
      wait_drained();

      useful_bytes = 0;
      msg_no = 0;
      while (useful_bytes < RANDOM_BYTES) begin
         msg_no++;
         pick = $urandom_range(0, 99);
         if (msg_no == 4) begin
            // full node store: a left spine of 256 internal nodes
            compose_message(MAX_LEAVES, 1'b1, -1, 16'd2, 2);
            send_stream(1'b1, 0);
         end else if (msg_no == 2) begin
            // 264 internal nodes, more than the 256 that the node store holds
            repeat (33) stream_bits.push_back(1'b0);
            repeat (33 * 7) stream_bits.push_back(1'b0);
            send_stream(1'b1, 2);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 18) begin
            // count far beyond the symbols actually supplied
            count = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(100, 65535));
            compose_message($urandom_range(1, 12), 1'b0, -1, count, $urandom_range(0, 6));
            send_stream(1'b1, 0);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               leaves = $urandom_range(1, 8);
            else if (pick < 92)
               leaves = $urandom_range(9, 40);
            else
               leaves = $urandom_range(41, 128);
            count = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
            shown = int'(count);
            send_stream_prep: begin
               compose_message(leaves, 1'b0, -1, count, shown);
            end
            send_stream(1'b1, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
         end
         if (msg_no % 12 == 0)
            wait_drained();
      end

      req_tvalid <= 1'b0;
      while (tracker.pending_count() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_count() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
